/* rtl/qslerp_pkg.sv */
package qslerp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 20;
  localparam int SQRT_STEPS   = 17;
  localparam int SQRT_W       = 34;
  localparam int ROOT_W       = 17;
  localparam int DIV_STEPS    = 30;
  localparam int NUM_W        = CORDIC_W + 16;
  localparam int DIVC_W       = ROOT_W + DIV_STEPS;

  localparam logic [14:0] THR_RESET = 15'd15565;

  typedef logic signed [CORDIC_W-1:0] cordic_t;

  localparam cordic_t CORDIC_GAIN = 20'sd39797;

  typedef struct packed {
    logic ovf;
    logic neg;
  } div_flags_t;

  function automatic cordic_t atan_q16(input int step);
    cordic_t a;
    case (step)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

endpackage

/* rtl/quaternion_slerp_core.sv */
// Quaternion slerp, fully pipelined.
// Input stream s_*: one item per start/end quaternion pair plus fraction.
// Output stream m_*: interpolated quaternion in tdata, used_linear in tuser.
// Config: cfg_we/cfg_wdata write lerp_threshold (Q1.14); write only when idle.
// Throughput: one item per cycle while the output is not stalled. The
// pipeline is built from the cell chains: 17 square-root cells, 16 vectoring
// CORDIC cells, and in each of two lanes 16 rotation CORDIC cells and 30
// divider cells, plus the dot-product, multiply and format registers.
// The output register is held while m_tready is low; the pipeline keeps
// accepting items until its last stage holds an item that cannot move on,
// then s_tready drops and every stage freezes.
// Reset (rst, synchronous) empties the pipeline and restores the threshold
// to 15565 (0.95).
module quaternion_slerp_core #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [14:0]                            cfg_wdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // start_w, start_x, start_y, start_z, end_w, end_x, end_y, end_z, fraction
  input  logic [8*COMPONENT_BITS+15:0]           s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // out_w, out_x, out_y, out_z, zero pad
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]  m_tdata,
  // used_linear
  output logic [0:0]                             m_tuser
);
  import qslerp_pkg::*;

  localparam int CB   = COMPONENT_BITS;
  localparam int F    = CB - 2;
  localparam int DOTW = CB + 4;
  localparam int PW   = CB + 34;
  localparam int TSL  = (F >= 14) ? F - 14 : 0;
  localparam int TSR  = (F >= 14) ? 0 : 14 - F;
  localparam int DSL  = (F >= 16) ? 0 : 16 - F;
  localparam int DSR  = (F >= 16) ? F - 16 : 0;
  localparam int OUTW = ((4*CB+7)/8)*8;

  localparam int S_NEG     = 2;
  localparam int S_SQ0     = 4;
  localparam int S_SQ_END  = S_SQ0 + SQRT_STEPS - 1;
  localparam int S_VEC0    = S_SQ_END + 1;
  localparam int S_VEC_END = S_VEC0 + CORDIC_STEPS - 1;
  localparam int S_ANG     = S_VEC_END + 1;
  localparam int S_ROT0    = S_ANG + 1;
  localparam int S_ROT_END = S_ROT0 + CORDIC_STEPS - 1;
  localparam int S_DPRE    = S_ROT_END + 1;
  localparam int S_DIV0    = S_DPRE + 1;
  localparam int S_DIV_END = S_DIV0 + DIV_STEPS - 1;
  localparam int S_MUL     = S_DIV_END + 1;
  localparam int NS        = S_MUL + 1;

  typedef struct packed {
    logic [3:0][CB-1:0]  q1;
    logic [3:0][CB:0]    q3;
    logic [15:0]         t;
    logic                lin;
    logic [ROOT_W-1:0]   d;
    logic [ROOT_W-1:0]   s;
  } side_t;

  side_t             sb    [NS];
  side_t             sb_nx [NS];
  logic [NS-1:0]     vld;
  logic              vld_out;
  logic              en;
  logic              out_free;
  logic [14:0]       lerp_threshold;
  logic [15:0]       frac;

  logic signed [2*CB-1:0] prod [4];
  logic signed [DOTW-1:0] dot;
  logic signed [DOTW-1:0] dot_nx;
  logic                   neg_dot;
  logic [DOTW-1:0]        adot;
  logic [DOTW-1:0]        thr_ext;
  logic [DOTW-1:0]        dcl;
  logic [DOTW+15:0]       dwide;
  logic [SQRT_W-1:0]      dsq;
  logic [SQRT_W-1:0]      rad;
  logic [ROOT_W-1:0]      root;

  logic [SQRT_W-1:0] sq_n [SQRT_STEPS+1];
  logic [SQRT_W-1:0] sq_r [SQRT_STEPS+1];
  cordic_t vx [CORDIC_STEPS+1];
  cordic_t vy [CORDIC_STEPS+1];
  cordic_t vz [CORDIC_STEPS+1];

  logic signed [CORDIC_W+16:0] m1, m2;
  logic [15:0]                 t_ang;
  cordic_t                     ang [2];
  cordic_t rx [2][CORDIC_STEPS+1];
  cordic_t ry [2][CORDIC_STEPS+1];
  cordic_t rz [2][CORDIC_STEPS+1];

  cordic_t             sine [2];
  logic [CORDIC_W-1:0] mag  [2];
  logic [NUM_W-1:0]    dr [2][DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dq [2][DIV_STEPS+1];
  logic [ROOT_W-1:0]   ds [2][DIV_STEPS+1];
  div_flags_t          df [2][DIV_STEPS+1];
  logic [NUM_W-1:0]    num_nx [2];
  div_flags_t          df_nx  [2];

  logic [30:0]             wmag [2];
  logic signed [31:0]      w    [2];
  logic signed [CB-1:0]    q1s  [4];
  logic signed [CB:0]      q3s  [4];
  logic signed [CB+1:0]    diff [4];
  logic signed [CB+18:0]   lp   [4];
  logic signed [CB+31:0]   sp1  [4];
  logic signed [CB+32:0]   sp2  [4];
  logic signed [PW-1:0]    pa_nx [4];
  logic signed [PW-1:0]    pb_nx [4];
  logic signed [PW-1:0]    pa    [4];
  logic signed [PW-1:0]    pb    [4];
  logic signed [PW:0]      sum   [4];
  logic signed [PW:0]      rsh   [4];
  logic [CB-1:0]           sat   [4];
  logic [CB-1:0]           out_q [4];
  logic                    out_lin;

  assign out_free = ~vld_out | m_tready;
  assign en       = out_free | ~vld[NS-1];
  assign s_tready = en;
  assign m_tvalid = vld_out;
  assign m_tdata  = OUTW'({out_q[3], out_q[2], out_q[1], out_q[0]});
  assign m_tuser  = out_lin;
  assign frac     = s_tdata[8*CB +: 16];
  assign root     = sq_r[SQRT_STEPS][ROOT_W-1:0];

  // sideband line with the few stages that rewrite it
  always_comb begin
    sb_nx[0] = '0;
    for (int i = 0; i < 4; i++) begin
      sb_nx[0].q1[i] = s_tdata[i*CB +: CB];
      sb_nx[0].q3[i] = {s_tdata[(i+4)*CB+CB-1], s_tdata[(i+4)*CB +: CB]};
    end
    sb_nx[0].t = (frac > 16'd32768) ? 16'd32768 : frac;
    for (int j = 1; j < NS; j++) begin
      sb_nx[j] = sb[j-1];
    end

    neg_dot = dot[DOTW-1];
    adot    = neg_dot ? -dot : dot;
    thr_ext = ({{(DOTW-15){1'b0}}, lerp_threshold} << TSL) >> TSR;
    dcl     = (adot > (DOTW'(1) << F)) ? (DOTW'(1) << F) : adot;
    dwide   = ({16'b0, dcl} << DSL) >> DSR;
    sb_nx[S_NEG].lin = adot >= thr_ext;
    sb_nx[S_NEG].d   = dwide[ROOT_W-1:0];
    for (int i = 0; i < 4; i++) begin
      sb_nx[S_NEG].q3[i] = neg_dot ? -sb[S_NEG-1].q3[i] : sb[S_NEG-1].q3[i];
    end

    sb_nx[S_VEC0].lin = sb[S_VEC0-1].lin | (root == '0);
    sb_nx[S_VEC0].s   = root;
  end

  always_comb begin
    dot_nx = '0;
    for (int i = 0; i < 4; i++) begin
      dot_nx = dot_nx + DOTW'(prod[i] >>> F);
    end
    dsq = {{(SQRT_W-ROOT_W){1'b0}}, sb[S_NEG].d} * {{(SQRT_W-ROOT_W){1'b0}}, sb[S_NEG].d};
    t_ang = sb[S_VEC_END].t;
    m1 = vz[CORDIC_STEPS] * $signed({1'b0, 16'd32768 - t_ang});
    m2 = vz[CORDIC_STEPS] * $signed({1'b0, t_ang});
    for (int l = 0; l < 2; l++) begin
      sine[l]   = ry[l][CORDIC_STEPS];
      mag[l]    = sine[l][CORDIC_W-1] ? -sine[l] : sine[l];
      num_nx[l] = {mag[l], 16'b0};
      df_nx[l].neg = sine[l][CORDIC_W-1];
      df_nx[l].ovf = {{(DIVC_W-NUM_W){1'b0}}, num_nx[l]} >=
                     ({{(DIVC_W-ROOT_W){1'b0}}, sb[S_ROT_END].s} << DIV_STEPS);
      wmag[l] = df[l][DIV_STEPS].ovf ? 31'h4000_0000 : {1'b0, dq[l][DIV_STEPS]};
      w[l]    = df[l][DIV_STEPS].neg ? -$signed({1'b0, wmag[l]}) : $signed({1'b0, wmag[l]});
    end
    for (int i = 0; i < 4; i++) begin
      q1s[i]   = $signed(sb[S_MUL-1].q1[i]);
      q3s[i]   = $signed(sb[S_MUL-1].q3[i]);
      diff[i]  = (CB+2)'(q3s[i]) - (CB+2)'(q1s[i]);
      lp[i]    = diff[i] * $signed({1'b0, sb[S_MUL-1].t});
      sp1[i]   = q1s[i] * w[0];
      sp2[i]   = q3s[i] * w[1];
      pa_nx[i] = sb[S_MUL-1].lin ? PW'(lp[i]) : PW'(sp1[i]);
      pb_nx[i] = sb[S_MUL-1].lin ? (PW'(q1s[i]) <<< 15) : PW'(sp2[i]);
      sum[i]   = (PW+1)'(pa[i]) + (PW+1)'(pb[i]);
      rsh[i]   = sb[NS-1].lin ? (sum[i] >>> 15) : (sum[i] >>> 16);
      if ((&rsh[i][PW:CB-1]) | ~(|rsh[i][PW:CB-1])) begin
        sat[i] = rsh[i][CB-1:0];
      end else if (rsh[i][PW]) begin
        sat[i] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(CB-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      vld_out        <= 1'b0;
      lerp_threshold <= THR_RESET;
    end else begin
      if (cfg_we) lerp_threshold <= cfg_wdata;
      if (en) vld <= {vld[NS-2:0], s_tvalid};
      if (out_free) vld_out <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NS; j++) begin
        sb[j] <= sb_nx[j];
      end
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(s_tdata[i*CB +: CB]) * $signed(s_tdata[(i+4)*CB +: CB]);
        pa[i]   <= pa_nx[i];
        pb[i]   <= pb_nx[i];
      end
      dot    <= dot_nx;
      rad    <= (SQRT_W'(1) << 32) - dsq;
      ang[0] <= CORDIC_W'(m1 >>> 15);
      ang[1] <= CORDIC_W'(m2 >>> 15);
      for (int l = 0; l < 2; l++) begin
        dr[l][0] <= num_nx[l];
        dq[l][0] <= '0;
        ds[l][0] <= sb[S_ROT_END].s;
        df[l][0] <= df_nx[l];
      end
    end
    if (out_free) begin
      for (int i = 0; i < 4; i++) begin
        out_q[i] <= sat[i];
      end
      out_lin <= sb[NS-1].lin;
    end
  end

  assign sq_n[0] = rad;
  assign sq_r[0] = '0;
  assign vx[0]   = {{(CORDIC_W-ROOT_W){1'b0}}, sb[S_SQ_END].d};
  assign vy[0]   = {{(CORDIC_W-ROOT_W){1'b0}}, root};
  assign vz[0]   = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qslerp_sqrt_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(en),
      .n_in(sq_n[k]), .root_in(sq_r[k]),
      .n(sq_n[k+1]), .root(sq_r[k+1])
    );
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    qslerp_vec_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(en),
      .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]),
      .x(vx[k+1]), .y(vy[k+1]), .z(vz[k+1])
    );
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign rx[l][0] = CORDIC_GAIN;
    assign ry[l][0] = '0;
    assign rz[l][0] = ang[l];
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      qslerp_rot_cell #(.STEP(k)) u_cell (
        .clk(clk), .en(en),
        .x_in(rx[l][k]), .y_in(ry[l][k]), .z_in(rz[l][k]),
        .x(rx[l][k+1]), .y(ry[l][k+1]), .z(rz[l][k+1])
      );
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      qslerp_div_cell #(.STEP(DIV_STEPS-1-k)) u_cell (
        .clk(clk), .en(en),
        .r_in(dr[l][k]), .q_in(dq[l][k]), .s_in(ds[l][k]), .f_in(df[l][k]),
        .r(dr[l][k+1]), .q(dq[l][k+1]), .s(ds[l][k+1]), .f(df[l][k+1])
      );
    end
  end

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[S_SQ_END] |-> sq_r[SQRT_STEPS] <= (SQRT_W'(1) << 16))
    else $error("square root out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[S_DIV_END] && !df[0][DIV_STEPS].ovf && ds[0][DIV_STEPS] != '0
      |-> dr[0][DIV_STEPS] < {{(NUM_W-ROOT_W){1'b0}}, ds[0][DIV_STEPS]})
    else $error("divider remainder not below divisor");

endmodule

/* rtl/qslerp_sqrt_cell.sv */
module qslerp_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [qslerp_pkg::SQRT_W-1:0]  n_in,
  input  logic [qslerp_pkg::SQRT_W-1:0]  root_in,
  output logic [qslerp_pkg::SQRT_W-1:0]  n,
  output logic [qslerp_pkg::SQRT_W-1:0]  root
);
  import qslerp_pkg::*;

  localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic [SQRT_W-1:0] trial;

  assign trial = root_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n    <= n_in - trial;
        root <= (root_in >> 1) + BIT;
      end else begin
        n    <= n_in;
        root <= root_in >> 1;
      end
    end
  end

endmodule

/* rtl/qslerp_vec_cell.sv */
module qslerp_vec_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  qslerp_pkg::cordic_t x_in,
  input  qslerp_pkg::cordic_t y_in,
  input  qslerp_pkg::cordic_t z_in,
  output qslerp_pkg::cordic_t x,
  output qslerp_pkg::cordic_t y,
  output qslerp_pkg::cordic_t z
);
  import qslerp_pkg::*;

  cordic_t dx, dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CORDIC_W-1]) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + atan_q16(STEP);
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - atan_q16(STEP);
      end
    end
  end

endmodule

/* rtl/qslerp_rot_cell.sv */
module qslerp_rot_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  qslerp_pkg::cordic_t x_in,
  input  qslerp_pkg::cordic_t y_in,
  input  qslerp_pkg::cordic_t z_in,
  output qslerp_pkg::cordic_t x,
  output qslerp_pkg::cordic_t y,
  output qslerp_pkg::cordic_t z
);
  import qslerp_pkg::*;

  cordic_t dx, dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[CORDIC_W-1]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - atan_q16(STEP);
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + atan_q16(STEP);
      end
    end
  end

endmodule

/* rtl/qslerp_div_cell.sv */
module qslerp_div_cell #(
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [qslerp_pkg::NUM_W-1:0]     r_in,
  input  logic [qslerp_pkg::DIV_STEPS-1:0] q_in,
  input  logic [qslerp_pkg::ROOT_W-1:0]    s_in,
  input  qslerp_pkg::div_flags_t           f_in,
  output logic [qslerp_pkg::NUM_W-1:0]     r,
  output logic [qslerp_pkg::DIV_STEPS-1:0] q,
  output logic [qslerp_pkg::ROOT_W-1:0]    s,
  output qslerp_pkg::div_flags_t           f
);
  import qslerp_pkg::*;

  logic [DIVC_W-1:0] sub;
  logic [DIVC_W-1:0] rext;

  assign sub  = {{(DIVC_W-ROOT_W){1'b0}}, s_in} << STEP;
  assign rext = {{(DIVC_W-NUM_W){1'b0}}, r_in};

  always_ff @(posedge clk) begin
    if (en) begin
      s <= s_in;
      f <= f_in;
      if (rext >= sub) begin
        r <= r_in - sub[NUM_W-1:0];
        q <= q_in | (DIV_STEPS'(1) << STEP);
      end else begin
        r <= r_in;
        q <= q_in;
      end
    end
  end

endmodule
